// ----- rtl/spi_pkg.sv -----
package spi_pkg;

   localparam int OP_W       = 2;
   localparam int REQ_DATA_W = 32;
   localparam int POS_W      = 12;
   localparam int RSP_DATA_W = 16;

   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
   localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

   typedef enum logic [1:0] {
      KIND_CLEAR,
      KIND_APPEND,
      KIND_QUERY,
      KIND_IGNORE
   } spi_kind_type;

   typedef struct packed {
      logic         valid;
      spi_kind_type kind;
   } spi_cmd_type;

endpackage

// ----- rtl/spi_front.sv -----
module spi_front
   import spi_pkg::*;
#(
   parameter int TIME_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [OP_W-1:0]       req_tuser,
   output spi_cmd_type           cmd,
   output logic [TIME_WIDTH-1:0] cmd_time,
   input  logic                  cmd_pop
);

   logic [1:0]            count_ff, count_in;
   logic                  wr_ptr_ff, wr_ptr_in;
   logic                  rd_ptr_ff, rd_ptr_in;
   spi_kind_type          kind_ff [2];
   logic [TIME_WIDTH-1:0] time_ff [2];
   spi_kind_type          kind_in;
   logic                  push;
   logic                  pop;

   always_comb begin
      unique case (req_tuser)
         OP_CLEAR:  kind_in = KIND_CLEAR;
         OP_APPEND: kind_in = KIND_APPEND;
         OP_QUERY:  kind_in = KIND_QUERY;
         default:   kind_in = KIND_IGNORE;
      endcase
   end

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign pop        = cmd_pop && (count_ff != 2'd0);

   always_comb begin
      count_in  = count_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         kind_ff[wr_ptr_ff] <= kind_in;
         time_ff[wr_ptr_ff] <= TIME_WIDTH'(req_tdata);
      end
   end

   assign cmd.valid = (count_ff != 2'd0);
   assign cmd.kind  = kind_ff[rd_ptr_ff];
   assign cmd_time  = time_ff[rd_ptr_ff];

endmodule

// ----- rtl/spi_back.sv -----
module spi_back
   import spi_pkg::*;
#(
   parameter int TABLE_DEPTH = 4096,
   parameter int TIME_WIDTH  = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  spi_cmd_type           cmd,
   input  logic [TIME_WIDTH-1:0] cmd_time,
   output logic                  cmd_pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int IW = $clog2(TABLE_DEPTH);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH1,
      ST_FETCH,
      ST_SEARCH2,
      ST_DONE
   } state_type;

   state_type             state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [TIME_WIDTH-1:0] last_ff, last_in;
   logic [TIME_WIDTH-1:0] key_ff, key_in;
   logic [CW-1:0]         lo_ff, lo_in;
   logic [CW-1:0]         hi_ff, hi_in;
   logic [CW-1:0]         mid_ff, mid_in;
   logic                  fnd_ff, fnd_in;
   logic                  out_valid_ff, out_valid_in;
   logic [RSP_DATA_W-1:0] out_data_ff, out_data_in;

   logic [TIME_WIDTH-1:0] mem [TABLE_DEPTH];
   logic [TIME_WIDTH-1:0] rd_data_ff;
   logic [IW-1:0]         rd_addr;
   logic                  wr_en;

   logic                  out_free;
   logic [CW-1:0]         step_lo;
   logic [CW-1:0]         step_hi;
   logic [CW-1:0]         step_mid;
   logic [CW-1:0]         below_m1;

   assign out_free = !out_valid_ff || rsp_tready;

   // One halving step of the lower-bound search on the entry just read.
   always_comb begin
      step_lo = lo_ff;
      step_hi = hi_ff;
      if (rd_data_ff < key_ff) begin
         step_lo = mid_ff + CW'(1);
      end else begin
         step_hi = mid_ff;
      end
      step_mid = step_lo + ((step_hi - step_lo) >> 1);
      below_m1 = step_lo - CW'(1);
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      last_in      = last_ff;
      key_in       = key_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      fnd_in       = fnd_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      cmd_pop      = 1'b0;
      wr_en        = 1'b0;
      rd_addr      = mid_ff[IW-1:0];

      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.valid) begin
               if (cmd.kind == KIND_QUERY) begin
                  cmd_pop = 1'b1;
                  key_in  = cmd_time;
                  lo_in   = '0;
                  hi_in   = count_ff;
                  mid_in  = count_ff >> 1;
                  rd_addr = mid_in[IW-1:0];
                  fnd_in  = 1'b0;
                  if (count_ff == '0) begin
                     state_in = ST_DONE;
                  end else begin
                     state_in = ST_SEARCH1;
                  end
               end else if (out_free) begin
                  cmd_pop      = 1'b1;
                  out_valid_in = 1'b1;
                  out_data_in  = '0;
                  unique case (cmd.kind)
                     KIND_CLEAR: begin
                        count_in = '0;
                     end
                     KIND_APPEND: begin
                        if (count_ff >= CW'(TABLE_DEPTH)) begin
                           out_data_in[POS_W+1] = 1'b1;
                        end else if (count_ff == '0 || last_ff <= cmd_time) begin
                           wr_en    = 1'b1;
                           count_in = count_ff + CW'(1);
                           last_in  = cmd_time;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end
         ST_SEARCH1: begin
            if (step_lo < step_hi) begin
               lo_in   = step_lo;
               hi_in   = step_hi;
               mid_in  = step_mid;
               rd_addr = step_mid[IW-1:0];
            end else if (step_lo == '0) begin
               lo_in    = '0;
               fnd_in   = 1'b0;
               state_in = ST_DONE;
            end else begin
               lo_in    = step_lo;
               rd_addr  = below_m1[IW-1:0];
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            key_in   = rd_data_ff;
            lo_in    = '0;
            hi_in    = lo_ff;
            mid_in   = lo_ff >> 1;
            rd_addr  = mid_in[IW-1:0];
            state_in = ST_SEARCH2;
         end
         ST_SEARCH2: begin
            if (step_lo < step_hi) begin
               lo_in   = step_lo;
               hi_in   = step_hi;
               mid_in  = step_mid;
               rd_addr = step_mid[IW-1:0];
            end else begin
               lo_in    = step_lo;
               fnd_in   = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_data_in  = {3'b000, POS_W'(lo_ff), fnd_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
      last_ff     <= last_in;
      key_ff      <= key_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mid_ff      <= mid_in;
      fnd_ff      <= fnd_in;
      out_data_ff <= out_data_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[IW-1:0]] <= cmd_time;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

// ----- rtl/sorted_predecessor_index.sv -----
// Clear, append and unmatched requests pass the two-entry queue and then the result register,
// one request a cycle when the result side keeps up and no query is in progress.
// A query runs two lower-bound searches over the stored times, one step a cycle over the
// table memory's registered read port.
// Synchronous reset empties the queue and the table; the memory itself is not cleared.
module sorted_predecessor_index
   import spi_pkg::*;
#(
   parameter int TABLE_DEPTH = 4096,
   parameter int TIME_WIDTH  = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // time_value[31:0]
   input  logic [OP_W-1:0]       req_tuser,  // op[1:0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata   // found[0], position[12:1], overflow[13], zero
);

   spi_cmd_type           cmd;
   logic [TIME_WIDTH-1:0] cmd_time;
   logic                  cmd_pop;

   spi_front #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .cmd_time   (cmd_time),
      .cmd_pop    (cmd_pop)
   );

   spi_back #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .TIME_WIDTH  (TIME_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .cmd_time   (cmd_time),
      .cmd_pop    (cmd_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
   import spi_pkg::*;

   localparam int TABLE_DEPTH = 4096;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int RANDOM_PER_PHASE = 260;
   localparam int FILL_COUNT = 300;
   localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

   typedef struct packed {
      logic             overflow;
      logic [POS_W-1:0] position;
      logic             found;
   } answer_type;

   class predecessor_checker;
      logic [REQ_DATA_W-1:0] stored_times [TABLE_DEPTH];
      int unsigned           stored_count;
      answer_type            awaited [$];
      int unsigned           errors;

      function new();
         stored_count = 0;
         errors = 0;
      endfunction

      function int unsigned count_below(logic [REQ_DATA_W-1:0] key);
         int unsigned lo;
         int unsigned hi;
         int unsigned mid;
         lo = 0;
         hi = stored_count;
         while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (stored_times[mid] < key) begin
               lo = mid + 1;
            end else begin
               hi = mid;
            end
         end
         return lo;
      endfunction

      function void take_request(logic [OP_W-1:0] op, logic [REQ_DATA_W-1:0] t_val);
         answer_type  ans;
         int unsigned below;
         ans = '0;
         case (op)
            OP_CLEAR: begin
               stored_count = 0;
            end
            OP_APPEND: begin
               if (stored_count >= TABLE_DEPTH) begin
                  ans.overflow = 1'b1;
               end else if (stored_count == 0 || stored_times[stored_count - 1] <= t_val) begin
                  stored_times[stored_count] = t_val;
                  stored_count++;
               end
            end
            OP_QUERY: begin
               below = count_below(t_val);
               if (below > 0) begin
                  ans.found = 1'b1;
                  ans.position = POS_W'(count_below(stored_times[below - 1]));
               end
            end
            default: begin
            end
         endcase
         awaited = {awaited, ans};
      endfunction

      task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
         if (errors < 100) begin
            $display("%0t mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
         end
         errors++;
      endtask

      task match_answer(logic [RSP_DATA_W-1:0] data);
         answer_type want;
         if (awaited.size() == 0) begin
            report_mismatch("response with no request outstanding", 32'(data), 32'd0);
            return;
         end
         want = awaited.pop_front();
         if (data[0] !== want.found) begin
            report_mismatch("found", 32'(data[0]), 32'(want.found));
         end
         if (data[POS_W:1] !== want.position) begin
            report_mismatch("position", 32'(data[POS_W:1]), 32'(want.position));
         end
         if (data[POS_W+1] !== want.overflow) begin
            report_mismatch("overflow", 32'(data[POS_W+1]), 32'(want.overflow));
         end
      endtask
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;  // time_value[31:0]
   logic [OP_W-1:0]       req_tuser;  // op[1:0]
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;  // found[0], position[12:1], overflow[13], zero

   predecessor_checker sb = new();
   int unsigned send_idle = 0;
   int unsigned rsp_stall = 0;
   int unsigned hold_len = 0;
   int unsigned issued = 0;

   sorted_predecessor_index dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic send_request(input logic [OP_W-1:0] op, input logic [REQ_DATA_W-1:0] t_val);
      @(negedge clock);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= t_val;
      do @(posedge clock); while (!req_tready);
      sb.take_request(op, t_val);
      if (op != OP_SPARE) begin
         issued++;
      end
   endtask

   function automatic logic [REQ_DATA_W-1:0] next_ascending_time();
      logic [REQ_DATA_W:0]   sum;
      logic [REQ_DATA_W-1:0] step;
      if (sb.stored_count == 0) begin
         return $urandom >> $urandom_range(31, 0);
      end
      case ($urandom_range(3))
         0: step = '0;
         1: step = $urandom_range(3);
         default: step = $urandom >> $urandom_range(31, 8);
      endcase
      sum = {1'b0, sb.stored_times[sb.stored_count - 1]} + step;
      return sum[REQ_DATA_W] ? '1 : sum[REQ_DATA_W-1:0];
   endfunction

   function automatic logic [REQ_DATA_W-1:0] pick_query_time();
      logic [REQ_DATA_W-1:0] ref_t;
      if (sb.stored_count == 0 || $urandom_range(4) == 0) begin
         case ($urandom_range(3))
            0: return '0;
            1: return '1;
            default: return $urandom;
         endcase
      end
      ref_t = sb.stored_times[$urandom_range(sb.stored_count - 1)];
      case ($urandom_range(2))
         0: return ref_t - 1;
         1: return ref_t;
         default: return ref_t + 1;
      endcase
   endfunction

   task automatic run_burst();
      int unsigned           appends;
      int unsigned           queries;
      logic [REQ_DATA_W-1:0] last;
      if ($urandom_range(3) != 0) begin
         send_request(OP_CLEAR, $urandom);
      end
      appends = ($urandom_range(9) == 0) ? $urandom_range(200, 30) : $urandom_range(12);
      for (int i = 0; i < appends; i++) begin
         last = (sb.stored_count > 0) ? sb.stored_times[sb.stored_count - 1] : '0;
         case ($urandom_range(19))
            0: begin
               if (last != 0) begin
                  send_request(OP_APPEND, $urandom_range(last - 1));
               end else begin
                  send_request(OP_APPEND, next_ascending_time());
               end
            end
            1: send_request(OP_SPARE, $urandom);
            2, 3, 4: send_request(OP_QUERY, pick_query_time());
            default: send_request(OP_APPEND, next_ascending_time());
         endcase
      end
      queries = $urandom_range(8, 1);
      repeat (queries) send_request(OP_QUERY, pick_query_time());
   endtask

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_len > 0) begin
            rsp_tready <= 1'b0;
            hold_len--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_stall);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.match_answer(rsp_tdata);
      end
   end

   initial begin
      int unsigned quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("FAILURE");
      $finish;
   end

   initial begin
      int unsigned target;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = OP_CLEAR;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_request(OP_QUERY, '0);
      send_request(OP_QUERY, '1);
      send_request(OP_SPARE, '1);
      send_request(OP_APPEND, '0);
      send_request(OP_QUERY, '0);
      send_request(OP_QUERY, 32'd1);
      send_request(OP_APPEND, '0);
      repeat (3) send_request(OP_APPEND, 32'd5);
      send_request(OP_QUERY, 32'd5);
      send_request(OP_QUERY, 32'd6);
      send_request(OP_APPEND, 32'd3);
      send_request(OP_QUERY, 32'd4);
      send_request(OP_APPEND, '1);
      send_request(OP_APPEND, '1);
      send_request(OP_QUERY, '1);
      send_request(OP_QUERY, 32'hFFFF_FFFE);
      send_request(OP_SPARE, 32'hA5A5_5A5A);
      send_request(OP_QUERY, 32'h8000_0000);
      send_request(OP_CLEAR, '1);
      send_request(OP_QUERY, '1);
      send_request(OP_APPEND, 32'h8000_0000);
      send_request(OP_QUERY, 32'h8000_0001);

      send_request(OP_CLEAR, '0);
      while (sb.stored_count < FILL_COUNT) begin
         send_request(OP_APPEND, next_ascending_time());
      end
      send_request(OP_APPEND, '1);
      send_request(OP_APPEND, '0);
      repeat (30) send_request(OP_QUERY, pick_query_time());
      send_request(OP_QUERY, '1);
      send_request(OP_QUERY, '0);
      send_request(OP_CLEAR, '0);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle = 0;
               rsp_stall = 0;
               // The result side holds off long enough for the block to fill and
               // refuse further requests while the sender keeps offering them.
               hold_len = 400;
            end
            1: begin
               send_idle = 71;
               rsp_stall = 0;
            end
            2: begin
               send_idle = 0;
               rsp_stall = 71;
            end
            default: begin
               send_idle = 34;
               rsp_stall = 34;
            end
         endcase
         target = issued + RANDOM_PER_PHASE;
         while (issued < target) begin
            if ($urandom_range(6) == 0) begin
               send_request(OP_W'($urandom_range(3)), $urandom);
            end else begin
               run_burst();
            end
         end
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);
      if (sb.errors == 0 && sb.awaited.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
